>>> src/hff_pkg.sv
// Shared types, constants and register codes of the hex float formatter.
package hff_pkg;

    localparam int MAX_FIELD_WIDTH = 63;
    localparam int PREC_MAX        = 52;
    localparam int FRAC_NIBBLES    = 13;
    localparam int EXP_BIAS        = 1023;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

    localparam logic [1:0] SIGN_MINUS = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;

    localparam logic [1:0] PAD_SPACE = 2'd0;
    localparam logic [1:0] PAD_ZERO  = 2'd1;
    localparam logic [1:0] PAD_LEFT  = 2'd2;

    localparam logic [2:0] REG_SIGN_MODE       = 3'd0;
    localparam logic [2:0] REG_ALTERNATE_FORM  = 3'd1;
    localparam logic [2:0] REG_PRECISION_GIVEN = 3'd2;
    localparam logic [2:0] REG_PRECISION       = 3'd3;
    localparam logic [2:0] REG_FIELD_WIDTH     = 3'd4;
    localparam logic [2:0] REG_PAD_MODE        = 3'd5;
    localparam logic [2:0] REG_UPPERCASE       = 3'd6;

    typedef struct packed {
        logic [1:0] sign_mode;
        logic       alternate_form;
        logic       precision_given;
        logic [5:0] precision;
        logic [5:0] field_width;
        logic [1:0] pad_mode;
        logic       uppercase;
    } cfg_t;

    // After classification and the rounding decision.
    typedef struct packed {
        logic        neg;
        logic        special;
        logic        nan;
        logic        use_prec;
        logic [5:0]  prec;
        logic        exp_neg;
        logic [9:0]  exp_mag;
        logic [52:0] trunc;
        logic [52:0] inc;
    } dec_t;

    // After the rounding add, trimming and the first exponent digits.
    typedef struct packed {
        logic        neg;
        logic        special;
        logic        nan;
        logic [53:0] kept;
        logic [5:0]  digits;
        logic        exp_neg;
        logic        exp_th;
        logic [3:0]  exp_h;
        logic [6:0]  exp_r;
        logic [2:0]  nd;
    } rnd_t;

    // Character layout of one value, consumed by the emitter.
    typedef struct packed {
        logic        special;
        logic        nan;
        logic        upper;
        logic        has_sign;
        logic [7:0]  sign_ch;
        logic [1:0]  lead;
        logic [51:0] frac;
        logic        has_point;
        logic [5:0]  frac_start;
        logic [5:0]  p_pos;
        logic [5:0]  exp_last;
        logic        exp_neg;
        logic [3:0][3:0] ed;
        logic [5:0]  pad_start;
        logic [5:0]  pad;
        logic        pad_zero;
        logic [5:0]  total;
    } lay_t;

endpackage

>>> src/hff_decode.sv
// First stage: field split, exponent, and round-to-nearest-even decision.
module hff_decode import hff_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] value_bits,
    input  cfg_t        cfg,
    output logic        out_valid,
    output dec_t        out_rec
);

    logic        valid_reg;
    dec_t        rec_reg, rec_next;
    logic [51:0] frac;
    logic [10:0] bexp;
    logic [52:0] full, lowmask, half, inc, rem;
    logic [5:0]  prec_sat, sh;
    logic        round, up;

    always_comb begin
        frac     = value_bits[51:0];
        bexp     = value_bits[62:52];
        full     = (bexp == 11'd0) ? {1'b0, frac} : {1'b1, frac};
        prec_sat = (cfg.precision > 6'(PREC_MAX)) ? 6'(PREC_MAX) : cfg.precision;
        round    = cfg.precision_given && (prec_sat < 6'(FRAC_NIBBLES));
        sh       = 6'd52 - {prec_sat[3:0], 2'b00};
        inc      = 53'd1 << sh;
        half     = 53'd1 << (sh - 6'd1);
        lowmask  = inc - 53'd1;
        rem      = full & lowmask;
        up       = (rem > half) || ((rem == half) && ((full & inc) != 53'd0));

        rec_next.neg      = value_bits[63];
        rec_next.special  = (bexp == EXP_ALL_ONES);
        rec_next.nan      = (frac != 52'd0);
        rec_next.use_prec = cfg.precision_given;
        rec_next.prec     = prec_sat;
        if (round) begin
            rec_next.trunc = full & ~lowmask;
            rec_next.inc   = up ? inc : 53'd0;
        end else begin
            rec_next.trunc = full;
            rec_next.inc   = 53'd0;
        end
        if (bexp == 11'd0) begin
            rec_next.exp_neg = (frac != 52'd0);
            rec_next.exp_mag = (frac != 52'd0) ? 10'(EXP_BIAS - 1) : 10'd0;
        end else if (bexp < 11'(EXP_BIAS)) begin
            rec_next.exp_neg = 1'b1;
            rec_next.exp_mag = 10'(11'(EXP_BIAS) - bexp);
        end else begin
            rec_next.exp_neg = 1'b0;
            rec_next.exp_mag = 10'(bexp - 11'(EXP_BIAS));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rec_reg <= rec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

>>> src/hff_round.sv
// Second stage: rounding add, trailing-zero trim and hundreds of the exponent.
module hff_round import hff_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  dec_t in_rec,
    output logic out_valid,
    output rnd_t out_rec
);

    logic        valid_reg;
    rnd_t        rec_reg, rec_next;
    logic [5:0]  trim;
    logic [9:0]  r;
    logic [15:0] hprod;
    logic [3:0]  h;

    always_comb begin
        trim = 6'd0;
        for (int i = 1; i <= FRAC_NIBBLES; i++) begin
            if (in_rec.trunc[52 - 4 * i +: 4] != 4'd0) begin
                trim = 6'(i);
            end
        end
        r     = (in_rec.exp_mag >= 10'd1000) ? in_rec.exp_mag - 10'd1000 : in_rec.exp_mag;
        hprod = 16'(r) * 16'd41;
        h     = hprod[15:12];

        rec_next.neg     = in_rec.neg;
        rec_next.special = in_rec.special;
        rec_next.nan     = in_rec.nan;
        rec_next.kept    = {1'b0, in_rec.trunc} + {1'b0, in_rec.inc};
        rec_next.digits  = in_rec.use_prec ? in_rec.prec : trim;
        rec_next.exp_neg = in_rec.exp_neg;
        rec_next.exp_th  = (in_rec.exp_mag >= 10'd1000);
        rec_next.exp_h   = h;
        rec_next.exp_r   = 7'(r - 10'(h) * 10'd100);
        if (in_rec.exp_mag >= 10'd1000) begin
            rec_next.nd = 3'd4;
        end else if (in_rec.exp_mag >= 10'd100) begin
            rec_next.nd = 3'd3;
        end else if (in_rec.exp_mag >= 10'd10) begin
            rec_next.nd = 3'd2;
        end else begin
            rec_next.nd = 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rec_reg <= rec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

>>> src/hff_layout.sv
// Third stage: exponent digits, segment offsets, padding and total length.
module hff_layout import hff_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  rnd_t in_rec,
    input  cfg_t cfg,
    output logic out_valid,
    output lay_t out_rec
);

    logic        valid_reg;
    lay_t        rec_reg, rec_next;
    logic [14:0] tprod;
    logic [3:0]  t;
    logic [6:0]  len;
    logic [5:0]  width;
    logic        sgn, pt;

    always_comb begin
        tprod = 15'(in_rec.exp_r) * 15'd205;
        t     = tprod[14:11];
        sgn   = in_rec.neg || (cfg.sign_mode == SIGN_PLUS) || (cfg.sign_mode == SIGN_SPACE);
        pt    = !in_rec.special && ((in_rec.digits != 6'd0) || cfg.alternate_form);
        width = (cfg.field_width > 6'(MAX_FIELD_WIDTH)) ? 6'(MAX_FIELD_WIDTH) : cfg.field_width;

        if (in_rec.special) begin
            len = 7'(sgn) + 7'd3;
        end else begin
            len = 7'(sgn) + 7'd5 + 7'(pt) + 7'(in_rec.digits) + 7'(in_rec.nd);
        end

        rec_next.special    = in_rec.special;
        rec_next.nan        = in_rec.nan;
        rec_next.upper      = cfg.uppercase;
        rec_next.has_sign   = sgn;
        rec_next.sign_ch    = in_rec.neg ? 8'h2D :
                              (cfg.sign_mode == SIGN_PLUS) ? 8'h2B : 8'h20;
        rec_next.lead       = in_rec.kept[53:52];
        rec_next.frac       = in_rec.kept[51:0];
        rec_next.has_point  = pt;
        rec_next.frac_start = 6'(sgn) + 6'd3 + 6'(pt);
        rec_next.p_pos      = 6'(sgn) + 6'd3 + 6'(pt) + in_rec.digits;
        rec_next.exp_last   = 6'(len - 7'd1);
        rec_next.exp_neg    = in_rec.exp_neg;
        rec_next.ed[0]      = 4'(in_rec.exp_r - 7'(t) * 7'd10);
        rec_next.ed[1]      = t;
        rec_next.ed[2]      = in_rec.exp_h;
        rec_next.ed[3]      = {3'd0, in_rec.exp_th};
        rec_next.pad        = (7'(width) > len) ? 6'(7'(width) - len) : 6'd0;
        rec_next.total      = (7'(width) > len) ? width : 6'(len);
        if (cfg.pad_mode == PAD_LEFT) begin
            rec_next.pad_start = 6'(len);
            rec_next.pad_zero  = 1'b0;
        end else if ((cfg.pad_mode == PAD_ZERO) && !in_rec.special) begin
            rec_next.pad_start = 6'(sgn) + 6'd2;
            rec_next.pad_zero  = 1'b1;
        end else begin
            rec_next.pad_start = 6'd0;
            rec_next.pad_zero  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rec_reg <= rec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

>>> src/hff_emit.sv
// Character sequencer: walks one layout record and drives the output register.
module hff_emit import hff_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  lay_t       in_rec,
    output logic       in_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic       busy_reg;
    lay_t       rec_reg;
    logic [5:0] k_reg;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    logic       out_en, issue, last, take;
    logic [6:0] pad_end;
    logic [5:0] j, fi, ei;
    logic [7:0] ch, hexc;
    logic [3:0] nib, ed_d;

    always_comb begin
        out_en  = !out_valid_reg || m_tready;
        issue   = busy_reg && out_en;
        last    = (k_reg == rec_reg.total - 6'd1);
        take    = !busy_reg || (issue && last);
        pad_end = 7'(rec_reg.pad_start) + 7'(rec_reg.pad);
        j       = (k_reg < rec_reg.pad_start) ? k_reg : k_reg - rec_reg.pad;
        fi      = j - rec_reg.frac_start;
        ei      = rec_reg.exp_last - j;
        ed_d    = rec_reg.ed[ei[1:0]];
        nib     = (fi < 6'(FRAC_NIBBLES)) ? rec_reg.frac[6'd48 - {fi[3:0], 2'b00} +: 4] : 4'd0;
        hexc    = (nib < 4'd10) ? 8'h30 + 8'(nib)
                                : (rec_reg.upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;

        if ((k_reg >= rec_reg.pad_start) && (7'(k_reg) < pad_end)) begin
            ch = rec_reg.pad_zero ? 8'h30 : 8'h20;
        end else if (rec_reg.has_sign && (j == 6'd0)) begin
            ch = rec_reg.sign_ch;
        end else if (rec_reg.special) begin
            case (j - 6'(rec_reg.has_sign))
                6'd0:    ch = rec_reg.nan ? 8'h6E : 8'h69;
                6'd1:    ch = rec_reg.nan ? 8'h61 : 8'h6E;
                default: ch = rec_reg.nan ? 8'h6E : 8'h66;
            endcase
            if (rec_reg.upper) begin
                ch = ch - 8'h20;
            end
        end else if (j == 6'(rec_reg.has_sign)) begin
            ch = 8'h30;
        end else if (j == 6'(rec_reg.has_sign) + 6'd1) begin
            ch = rec_reg.upper ? 8'h58 : 8'h78;
        end else if (j == 6'(rec_reg.has_sign) + 6'd2) begin
            ch = 8'h30 + 8'(rec_reg.lead);
        end else if (j < rec_reg.frac_start) begin
            ch = 8'h2E;
        end else if (j < rec_reg.p_pos) begin
            ch = hexc;
        end else if (j == rec_reg.p_pos) begin
            ch = rec_reg.upper ? 8'h50 : 8'h70;
        end else if (j == rec_reg.p_pos + 6'd1) begin
            ch = rec_reg.exp_neg ? 8'h2D : 8'h2B;
        end else begin
            ch = 8'h30 + 8'(ed_d);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_en) begin
                out_valid_reg <= issue;
            end
            if (take) begin
                busy_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            rec_reg <= in_rec;
            k_reg   <= 6'd0;
        end else if (issue) begin
            k_reg <= k_reg + 6'd1;
        end
        if (issue) begin
            out_char_reg <= ch;
            out_last_reg <= last;
        end
    end

    assign in_ready = take;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> src/hex_float_formatter.sv
// Top level of the hex float formatter: register file, pipeline and emitter.
// An accepted value passes the decode, round and layout registers and the emitter's record
// and output registers. Throughput: one character per cycle unless m_tready stalls; a value
// is the larger of text length and field width (3 to 63 characters); values follow with no gap.
// Reset: aresetn is synchronous and active low; it empties the pipeline and the output
// register and clears the configuration registers to zero.
module hex_float_formatter import hff_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value_bits
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast,   // last_char
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg_reg;
    logic wr;

    // A register write completes in the access phase; pready is tied high.
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr) begin
            unique case (paddr[4:2])
                REG_SIGN_MODE:       cfg_reg.sign_mode       <= pwdata[1:0];
                REG_ALTERNATE_FORM:  cfg_reg.alternate_form  <= pwdata[0];
                REG_PRECISION_GIVEN: cfg_reg.precision_given <= pwdata[0];
                REG_PRECISION:       cfg_reg.precision       <= pwdata[5:0];
                REG_FIELD_WIDTH:     cfg_reg.field_width     <= pwdata[5:0];
                REG_PAD_MODE:        cfg_reg.pad_mode        <= pwdata[1:0];
                REG_UPPERCASE:       cfg_reg.uppercase       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SIGN_MODE:       prdata = {30'd0, cfg_reg.sign_mode};
            REG_ALTERNATE_FORM:  prdata = {31'd0, cfg_reg.alternate_form};
            REG_PRECISION_GIVEN: prdata = {31'd0, cfg_reg.precision_given};
            REG_PRECISION:       prdata = {26'd0, cfg_reg.precision};
            REG_FIELD_WIDTH:     prdata = {26'd0, cfg_reg.field_width};
            REG_PAD_MODE:        prdata = {30'd0, cfg_reg.pad_mode};
            REG_UPPERCASE:       prdata = {31'd0, cfg_reg.uppercase};
            default:             prdata = 32'd0;
        endcase
    end

    // Each stage advances when it is empty or when the stage after it advances,
    // so a stall at the emitter backs up the pipeline without losing a transfer.
    logic d_valid, r_valid, l_valid, emit_ready;
    logic en_d, en_r, en_l;
    dec_t d_rec;
    rnd_t r_rec;
    lay_t l_rec;

    assign en_l     = !l_valid || emit_ready;
    assign en_r     = !r_valid || en_l;
    assign en_d     = !d_valid || en_r;
    assign s_tready = en_d;

    hff_decode u_decode (
        .aclk, .aresetn, .en(en_d), .in_valid(s_tvalid), .value_bits(s_tdata),
        .cfg(cfg_reg), .out_valid(d_valid), .out_rec(d_rec)
    );

    hff_round u_round (
        .aclk, .aresetn, .en(en_r), .in_valid(d_valid), .in_rec(d_rec),
        .out_valid(r_valid), .out_rec(r_rec)
    );

    hff_layout u_layout (
        .aclk, .aresetn, .en(en_l), .in_valid(r_valid), .in_rec(r_rec),
        .cfg(cfg_reg), .out_valid(l_valid), .out_rec(l_rec)
    );

    hff_emit u_emit (
        .aclk, .aresetn, .in_valid(l_valid), .in_rec(l_rec), .in_ready(emit_ready),
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );

endmodule

>>> src/hff_checker.sv
// Port-level checker for the hex float formatter, bound to the top level.
module hff_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled transfer keeps its character and flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Every character is printable ASCII.
    a_print: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >= 8'h20) && (m_tdata <= 8'h7E))
        else $error("non-printable character");

    // A value ends in an exponent digit, a padding space or the end of inf/nan.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> ((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) ||
            (m_tdata == 8'h20) || (m_tdata == 8'h66) || (m_tdata == 8'h46) ||
            (m_tdata == 8'h6E) || (m_tdata == 8'h4E))
        else $error("bad final character");

endmodule

bind hex_float_formatter hff_checker u_hff_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);

>>> sim/tb_hex_float_formatter.sv
// Self-checking testbench of the hex float formatter: directed and random values and settings.
`timescale 1ns / 100ps

module tb_hex_float_formatter;
    import hff_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [63:0] value_bits
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_char
    logic        m_tlast;   // last_char
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hex_float_formatter uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Each expected character carries its last-character flag in bit 8.
    logic [8:0] char_queue[$];
    cfg_t       fmt;
    int         errors = 0;
    bit         quiet_in;   // idling disabled on the sender for a stretch
    bit         quiet_out;  // idling disabled on the receiver for a stretch

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // A generous bound: 484 values of up to 63 characters with stalls, plus reconfiguration.
    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [7:0] nibble_char(logic [3:0] n);
        if (n < 10) return 8'h30 + 8'(n);
        return (fmt.uppercase ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // Builds the expected text of one value under the current settings and queues it.
    task automatic format_value(logic [63:0] bits);
        logic [7:0]  body[$];
        logic [7:0]  text[$];
        logic [51:0] frac;
        logic [10:0] bexp;
        logic [63:0] full, kept, rem, half;
        int          prec, width, head, pad, digits, e, mag, sh;
        bit          special;
        string       dec;
        prec = (fmt.precision > PREC_MAX) ? PREC_MAX : fmt.precision;
        width = fmt.field_width;
        frac = bits[51:0];
        bexp = bits[62:52];
        special = 0;
        kept = 0;
        e = 0;
        if (bits[63]) body.push_back("-");
        else if (fmt.sign_mode == SIGN_PLUS) body.push_back("+");
        else if (fmt.sign_mode == SIGN_SPACE) body.push_back(" ");
        head = body.size();
        if (bexp == EXP_ALL_ONES) begin
            special = 1;
            if (frac != 0) begin
                body.push_back(fmt.uppercase ? "N" : "n");
                body.push_back(fmt.uppercase ? "A" : "a");
                body.push_back(fmt.uppercase ? "N" : "n");
            end else begin
                body.push_back(fmt.uppercase ? "I" : "i");
                body.push_back(fmt.uppercase ? "N" : "n");
                body.push_back(fmt.uppercase ? "F" : "f");
            end
        end else begin
            body.push_back("0");
            body.push_back(fmt.uppercase ? "X" : "x");
            head = body.size();
            if (bexp == 0 && frac == 0) begin
                digits = fmt.precision_given ? prec : 0;
            end else begin
                full = (bexp == 0) ? {12'd0, frac} : {11'd0, 1'b1, frac};
                e = ((bexp == 0) ? 1 : int'(bexp)) - EXP_BIAS;
                if (fmt.precision_given) begin
                    digits = prec;
                    if (prec < FRAC_NIBBLES) begin
                        sh = 52 - 4 * prec;
                        rem = full & ((64'd1 << sh) - 1);
                        half = 64'd1 << (sh - 1);
                        kept = full >> sh;
                        // Round to nearest, ties to even; a carry may raise the lead digit.
                        if (rem > half || (rem == half && kept[0])) kept++;
                        full = kept << sh;
                    end
                end else begin
                    digits = FRAC_NIBBLES;
                    while (digits > 0 && ((full >> (52 - 4 * digits)) & 64'hF) == 0)
                        digits--;
                end
                kept = full;
            end
            body.push_back(8'h30 + 8'(kept >> 52));
            if (digits > 0 || fmt.alternate_form) body.push_back(".");
            for (int i = 1; i <= digits; i++)
                body.push_back(nibble_char(i <= FRAC_NIBBLES ? 4'(kept >> (52 - 4 * i)) : 4'd0));
            body.push_back(fmt.uppercase ? "P" : "p");
            body.push_back(e < 0 ? "-" : "+");
            mag = (e < 0) ? -e : e;
            dec = $sformatf("%0d", mag);
            foreach (dec[i]) body.push_back(dec[i]);
        end
        pad = (width > body.size()) ? width - body.size() : 0;
        if (pad == 0) begin
            text = body;
        end else if (fmt.pad_mode == PAD_LEFT) begin
            text = body;
            repeat (pad) text.push_back(" ");
        end else if (fmt.pad_mode == PAD_ZERO && !special) begin
            // Zeros go after the sign and the 0x prefix.
            for (int i = 0; i < head; i++) text.push_back(body[i]);
            repeat (pad) text.push_back("0");
            for (int i = head; i < body.size(); i++) text.push_back(body[i]);
        end else begin
            repeat (pad) text.push_back(" ");
            foreach (body[i]) text.push_back(body[i]);
        end
        foreach (text[i]) char_queue.push_back({i == text.size() - 1, text[i]});
    endtask

    // Receiver: random stalls, and every transfer compared with the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet_out || ($urandom_range(99) >= 8);
            if (m_tvalid && m_tready) begin
                if (char_queue.size() == 0) begin
                    $display("%0t: unexpected character %h last %b", $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    if ({m_tlast, m_tdata} !== char_queue[0]) begin
                        $display("%0t: expected char %h last %b, actual char %h last %b", $time,
                                 char_queue[0][7:0], char_queue[0][8], m_tdata, m_tlast);
                        errors++;
                    end
                    void'(char_queue.pop_front());
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_SIGN_MODE:       fmt.sign_mode = value[1:0];
            REG_ALTERNATE_FORM:  fmt.alternate_form = value[0];
            REG_PRECISION_GIVEN: fmt.precision_given = value[0];
            REG_PRECISION:       fmt.precision = value[5:0];
            REG_FIELD_WIDTH:     fmt.field_width = value[5:0];
            REG_PAD_MODE:        fmt.pad_mode = value[1:0];
            REG_UPPERCASE:       fmt.uppercase = value[0];
            default: ;
        endcase
    endtask

    // Registers may change only once every expected character has come out.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (char_queue.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_setting(cfg_t c);
        drain();
        write_reg(REG_SIGN_MODE, 32'(c.sign_mode));
        write_reg(REG_ALTERNATE_FORM, 32'(c.alternate_form));
        write_reg(REG_PRECISION_GIVEN, 32'(c.precision_given));
        write_reg(REG_PRECISION, 32'(c.precision));
        write_reg(REG_FIELD_WIDTH, 32'(c.field_width));
        write_reg(REG_PAD_MODE, 32'(c.pad_mode));
        write_reg(REG_UPPERCASE, 32'(c.uppercase));
    endtask

    // One transfer on the input side, with random gaps before it.
    task automatic send_value(logic [63:0] bits);
        while (!quiet_in && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= bits;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        format_value(bits);
    endtask

    // Random values biased toward the interesting classes of binary64.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0: v[62:52] = 11'd0;
            1: v[62:52] = EXP_ALL_ONES;
            2: v[51:0] = 52'd0;
            3: v[51:0] = {4'($urandom_range(15)), 48'd0} | (52'd1 << $urandom_range(51));
            4: v[51:0] = 52'hFFFFF_FFFFFFFF ^ (52'd1 << $urandom_range(51));
            5: v[62:0] = {$urandom_range(1) ? 11'd0 : 11'h7FF, 52'd0};
            default: ;
        endcase
        return v;
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        c.sign_mode = 2'($urandom_range(3));
        c.alternate_form = 1'($urandom_range(1));
        c.precision_given = 1'($urandom_range(1));
        c.precision = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) :
                      6'($urandom_range(14));
        c.field_width = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) :
                        6'($urandom_range(24));
        c.pad_mode = 2'($urandom_range(3));
        c.uppercase = 1'($urandom_range(1));
        return c;
    endfunction

    typedef struct {
        logic [63:0] bits;
        string       text;   // empty where the predictor decides
    } case_t;

    // Directed values under the reset setting; short fixed texts are typed in directly.
    case_t directed[] = '{
        '{64'h0000_0000_0000_0000, "0x0p+0"},
        '{64'h8000_0000_0000_0000, "-0x0p+0"},
        '{64'h3FF0_0000_0000_0000, "0x1p+0"},
        '{64'h7FF0_0000_0000_0000, "inf"},
        '{64'hFFF0_0000_0000_0000, "-inf"},
        '{64'h7FF8_0000_0000_0000, "nan"},
        '{64'hFFF8_0000_0000_0001, "-nan"},
        '{64'h0000_0000_0000_0001, "0x0.0000000000001p-1022"},
        '{64'h7FEF_FFFF_FFFF_FFFF, "0x1.fffffffffffffp+1023"},
        '{64'h0010_0000_0000_0000, "0x1p-1022"},
        '{64'hFFFF_FFFF_FFFF_FFFF, ""},
        '{64'h000F_FFFF_FFFF_FFFF, ""},
        '{64'h4000_0000_0000_0000, ""},
        '{64'h3FB9_9999_9999_999A, ""},
        '{64'hC00A_AAAA_AAAA_AAAA, ""}
    };

    cfg_t setting;

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fmt = '0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            logic [8:0] tail[$];
            // A typed-in row starts from an empty queue, so only its own text is replaced.
            if (directed[i].text.len() != 0) drain();
            send_value(directed[i].bits);
            if (directed[i].text.len() != 0) begin
                // Replace the predicted text with the typed-in one; they should agree.
                tail = char_queue;
                repeat (tail.size()) void'(char_queue.pop_back());
                foreach (directed[i].text[k])
                    char_queue.push_back({k == directed[i].text.len() - 1,
                                          8'(directed[i].text[k])});
                drain();
            end
        end

        // Extreme settings: widest field with zero padding, plus and precision 52, then
        // precision zero with the rounding carry, unused codes and large precision.
        setting = '{SIGN_PLUS, 1'b1, 1'b1, 6'd52, 6'd63, PAD_ZERO, 1'b1};
        apply_setting(setting);
        foreach (directed[i]) send_value(directed[i].bits);
        setting = '{2'd3, 1'b0, 1'b1, 6'd0, 6'd20, 2'd3, 1'b0};
        apply_setting(setting);
        send_value(64'h3FFF_FFFF_FFFF_FFFF);
        send_value(64'h3FF8_0000_0000_0000);
        send_value(64'h3FF7_FFFF_FFFF_FFFF);
        send_value(64'h000F_FFFF_FFFF_FFFF);
        setting = '{SIGN_SPACE, 1'b1, 1'b1, 6'd63, 6'd40, PAD_LEFT, 1'b0};
        apply_setting(setting);
        send_value(64'h3FF1_2345_6789_ABCD);
        send_value(64'hFFF0_0000_0000_0000);

        // Random phases, each under a fresh setting.
        for (int phase = 0; phase < 16; phase++) begin
            apply_setting(random_setting());
            quiet_in = (phase == 5);
            quiet_out = (phase == 5);
            for (int n = 0; n < 28; n++) begin
                send_value(random_value());
                // The sender sometimes holds off until the block has fully drained.
                if (n == 10 && phase % 4 == 0) drain();
            end
        end
        quiet_in = 1'b0;
        quiet_out = 1'b0;

        fork
            drain();
            begin
                repeat (100000) @(posedge aclk);
            end
        join_any
        disable fork;
        if (char_queue.size() != 0) begin
            $display("%0t: %0d characters never arrived", $time, char_queue.size());
        end
        if (errors == 0 && char_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/hff_pkg.sv
src/hff_decode.sv
src/hff_round.sv
src/hff_layout.sv
src/hff_emit.sv
src/hex_float_formatter.sv
src/hff_checker.sv
sim/tb_hex_float_formatter.sv
